// ----- src/mokp_pkg.sv -----
// ----------------------------------------------------------------------------
// mokp_pkg: shared types and constants
// Entry layout, command codes and cell control for the move-ordering store.
// ----------------------------------------------------------------------------
`default_nettype none

package mokp_pkg;

    localparam int MAX_PLY    = 32;
    localparam int PLY_W      = $clog2(MAX_PLY);
    localparam int DEPTH_W    = 6;
    localparam int MOVE_BITS  = 32;
    localparam int PIECE_BITS = 8;
    localparam int ENTRY_W    = MOVE_BITS + PIECE_BITS;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [PLY_W-1:0]   ply_t;

    // move code in the low bits, piece above it
    localparam entry_t EMPTY_ENTRY = {{PIECE_BITS{1'b0}}, {MOVE_BITS{1'b1}}};

    localparam logic [2:0] CMD_SCORE     = 3'd0;
    localparam logic [2:0] CMD_KILLER    = 3'd1;
    localparam logic [2:0] CMD_PV_UPDATE = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_PV_READ   = 3'd4;

    localparam logic [8:0] SCORE_PV      = 9'd100;
    localparam logic [8:0] SCORE_KILLER1 = 9'd80;
    localparam logic [8:0] SCORE_KILLER2 = 9'd79;
    localparam logic [8:0] SCORE_HASH    = 9'd90;

    typedef struct packed {
        logic   rd_en;
        ply_t   rd_row;
        logic   wr_en;
        ply_t   wr_row;
        logic   wr_copy;
        entry_t wr_data;
        logic   kill_clr;
        logic   kill_wr;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/mokp_cell.sv -----
// ----------------------------------------------------------------------------
// mokp_cell: one column of the pv table plus one killer pair
// Column memory with registered read, copy-from-read write path, killer slots.
// ----------------------------------------------------------------------------
`default_nettype none

module mokp_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mokp_pkg::cell_ctl_t ctl,
    output mokp_pkg::entry_t        rd_data,
    output mokp_pkg::entry_t        k0,
    output mokp_pkg::entry_t        k1
);
    import mokp_pkg::*;

    entry_t mem [MAX_PLY];
    entry_t rd_data_reg;
    entry_t k0_reg;
    entry_t k1_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_row];
        end
        if (ctl.wr_en)
        begin
            // copy takes the row read in the previous cycle
            mem[ctl.wr_row] <= ctl.wr_copy ? rd_data_reg : ctl.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k0_reg <= EMPTY_ENTRY;
            k1_reg <= EMPTY_ENTRY;
        end
        else if (ctl.kill_clr)
        begin
            k0_reg <= EMPTY_ENTRY;
            k1_reg <= EMPTY_ENTRY;
        end
        else if (ctl.kill_wr)
        begin
            if (ctl.wr_data != k0_reg)
            begin
                k1_reg <= k0_reg;
            end
            k0_reg <= ctl.wr_data;
        end
    end

    assign rd_data = rd_data_reg;
    assign k0      = k0_reg;
    assign k1      = k1_reg;

endmodule

`default_nettype wire

// ----- src/move_ordering_killer_pv_table_core.sv -----
// ----------------------------------------------------------------------------
// move_ordering_killer_pv_table_core: killer moves and triangular pv table
// Row of column cells; commands are broadcast and each cell acts on its column.
// ----------------------------------------------------------------------------
// flow: for every command but clear, the input transfer reads the pv columns and the
// execute state registers the result; clear sweeps all pv rows before its result
// input: a new command is taken only in the idle state once the single result
// register has been accepted, so that register holds off the input
// reset: killers empty at once, then a sweep of all pv rows with input not ready
`default_nettype none

module move_ordering_killer_pv_table_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [5:0]  cfg_wr_data,    // iteration_depth
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[2:0] ply[7:3] column[12:8] move_code[44:13] piece[52:45]
    // hash_move_code[84:53] hash_piece[92:85]
    input  wire logic [95:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,   // leaf_flag
    input  wire logic        s_axis_tlast,   // last_in_list
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // score[8:0] read_move_code[40:9] read_piece[48:41]
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast    // last_out
);
    import mokp_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

    state_t                state_reg;
    logic   [DEPTH_W-1:0]  depth_reg;
    logic   [2:0]          cmd_reg;
    ply_t                  ply_reg;
    ply_t                  col_reg;
    entry_t                mv_reg;
    entry_t                hmv_reg;
    logic                  leaf_reg;
    logic                  last_reg;
    ply_t                  clr_cnt_reg;
    logic                  clr_rsp_reg;
    logic                  out_valid_reg;
    logic   [8:0]          score_reg;
    entry_t                rd_entry_reg;
    logic                  last_out_reg;

    cell_ctl_t             ctl     [MAX_PLY];
    entry_t                rd_data [MAX_PLY];
    entry_t                k0      [MAX_PLY];
    entry_t                k1      [MAX_PLY];

    logic                  in_xfer;
    logic   [2:0]          in_cmd;
    ply_t                  in_ply;
    logic   [DEPTH_W-1:0]  nxt;
    logic                  copy_ok;
    logic                  leaf_ok;
    logic   [8:0]          score_next;

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tdata[2:0];
    assign in_ply        = s_axis_tdata[7:3];

    assign nxt     = DEPTH_W'(ply_reg) + DEPTH_W'(1);
    assign copy_ok = (nxt != depth_reg) && !leaf_reg && (nxt < DEPTH_W'(MAX_PLY));
    assign leaf_ok = (nxt != depth_reg) && leaf_reg;

    always_comb
    begin
        for (int c = 0; c < MAX_PLY; c++)
        begin
            ctl[c].rd_en    = in_xfer;
            ctl[c].rd_row   = (in_cmd == CMD_PV_UPDATE) ? in_ply + ply_t'(1) : in_ply;
            ctl[c].wr_en    = 1'b0;
            ctl[c].wr_row   = ply_reg;
            ctl[c].wr_copy  = 1'b0;
            ctl[c].wr_data  = mv_reg;
            ctl[c].kill_clr = 1'b0;
            ctl[c].kill_wr  = 1'b0;
            if (state_reg == ST_CLEAR)
            begin
                ctl[c].wr_en   = 1'b1;
                ctl[c].wr_row  = clr_cnt_reg;
                ctl[c].wr_data = EMPTY_ENTRY;
            end
            else if (state_reg == ST_EXEC)
            begin
                case (cmd_reg)
                    CMD_KILLER:
                    begin
                        ctl[c].kill_wr = (ply_t'(c) == ply_reg);
                    end
                    CMD_PV_UPDATE:
                    begin
                        if (ply_t'(c) == ply_reg)
                        begin
                            ctl[c].wr_en = 1'b1;
                        end
                        else if (leaf_ok && (DEPTH_W'(c) == nxt))
                        begin
                            ctl[c].wr_en   = 1'b1;
                            ctl[c].wr_data = EMPTY_ENTRY;
                        end
                        else if (copy_ok && (DEPTH_W'(c) >= nxt)
                                 && (DEPTH_W'(c) < depth_reg))
                        begin
                            ctl[c].wr_en   = 1'b1;
                            ctl[c].wr_copy = 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        ctl[c].kill_clr = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    for (genvar g = 0; g < MAX_PLY; g++)
    begin : g_cell
        mokp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl[g]),
            .rd_data (rd_data[g]),
            .k0      (k0[g]),
            .k1      (k1[g])
        );
    end

    always_comb
    begin
        score_next = 9'd0;
        if (mv_reg == rd_data[ply_reg])
        begin
            score_next = score_next + SCORE_PV;
        end
        if (mv_reg == k0[ply_reg])
        begin
            score_next = score_next + SCORE_KILLER1;
        end
        if (mv_reg == k1[ply_reg])
        begin
            score_next = score_next + SCORE_KILLER2;
        end
        if (mv_reg == hmv_reg)
        begin
            score_next = score_next + SCORE_HASH;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg  <= in_cmd;
            ply_reg  <= in_ply;
            col_reg  <= s_axis_tdata[12:8];
            mv_reg   <= {s_axis_tdata[45 +: PIECE_BITS], s_axis_tdata[13 +: MOVE_BITS]};
            hmv_reg  <= {s_axis_tdata[85 +: PIECE_BITS], s_axis_tdata[53 +: MOVE_BITS]};
            leaf_reg <= s_axis_tuser;
            last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            depth_reg     <= DEPTH_W'(32);
            clr_cnt_reg   <= '0;
            clr_rsp_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            score_reg     <= '0;
            rd_entry_reg  <= '0;
            last_out_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                depth_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ply_t'(1);
                    if (clr_cnt_reg == ply_t'(MAX_PLY - 1))
                    begin
                        state_reg <= ST_IDLE;
                        if (clr_rsp_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            score_reg     <= '0;
                            rd_entry_reg  <= '0;
                            last_out_reg  <= 1'b0;
                        end
                    end
                end
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    score_reg    <= '0;
                    rd_entry_reg <= '0;
                    last_out_reg <= 1'b0;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        state_reg   <= ST_CLEAR;
                        clr_cnt_reg <= '0;
                        clr_rsp_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        if (cmd_reg == CMD_SCORE)
                        begin
                            score_reg    <= score_next;
                            last_out_reg <= last_reg;
                        end
                        else if (cmd_reg == CMD_PV_READ)
                        begin
                            rd_entry_reg <= rd_data[col_reg];
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = last_out_reg;
    assign m_axis_tdata  = {7'd0, 8'(rd_entry_reg[ENTRY_W-1:MOVE_BITS]),
                            32'(rd_entry_reg[MOVE_BITS-1:0]), score_reg};

endmodule

`default_nettype wire

// ----- tb/tb_move_ordering_killer_pv_table_core.sv -----
// ----------------------------------------------------------------------------
// tb_move_ordering_killer_pv_table_core: killer and pv table stream check
// Directed rows with a few typed-in expectations, then random command
// sequences checked against a behavioral model of the killer and pv stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_move_ordering_killer_pv_table_core;
    import mokp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1430;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  ply;
        logic [4:0]  column;
        logic [31:0] mcode;
        logic [7:0]  mpiece;
        logic [31:0] hcode;
        logic [7:0]  hpiece;
        logic        leaf;
        logic        last;
    } move_req_t;

    typedef struct packed {
        logic [8:0]  score;
        logic [31:0] rcode;
        logic [7:0]  rpiece;
        logic        last;
    } order_res_t;

    typedef struct {
        move_req_t  req;
        logic       has_res;
        order_res_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [5:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    move_ordering_killer_pv_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    entry_t     killers [MAX_PLY*2];
    entry_t     pv_rows [MAX_PLY*MAX_PLY];
    logic [5:0] depth_reg;
    order_res_t expected_q[$];
    int         errors;
    int         cycles;
    bit         idle_free;
    bit         hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[move_ordering_killer_pv_table_core] ERROR");
                $finish;
            end
        end
    end

    function automatic entry_t mk_entry(logic [31:0] c, logic [7:0] p);
        return {p, c};
    endfunction

    function automatic entry_t pv_get(int r, int c);
        if (r >= MAX_PLY || c >= MAX_PLY)
            return EMPTY_ENTRY;
        return pv_rows[r*MAX_PLY + c];
    endfunction

    function automatic void wipe_stores();
        foreach (killers[i]) killers[i] = EMPTY_ENTRY;
        foreach (pv_rows[i]) pv_rows[i] = EMPTY_ENTRY;
    endfunction

    // apply one command to the store model and return its result
    function automatic order_res_t order_step(move_req_t r);
        order_res_t o;
        entry_t     mv;
        entry_t     e;
        int         p;
        int         nxt;
        o = '0;
        mv = mk_entry(r.mcode, r.mpiece);
        p = r.ply;
        case (r.cmd)
            CMD_SCORE:
            begin
                if (mv == pv_get(p, p)) o.score += SCORE_PV;
                if (mv == killers[p*2]) o.score += SCORE_KILLER1;
                if (mv == killers[p*2+1]) o.score += SCORE_KILLER2;
                if (mv == mk_entry(r.hcode, r.hpiece)) o.score += SCORE_HASH;
                o.last = r.last;
            end
            CMD_KILLER:
            begin
                if (mv != killers[p*2])
                    killers[p*2+1] = killers[p*2];
                killers[p*2] = mv;
            end
            CMD_PV_UPDATE:
            begin
                nxt = p + 1;
                pv_rows[p*MAX_PLY + p] = mv;
                if (nxt != depth_reg && nxt < MAX_PLY)
                begin
                    if (r.leaf)
                        pv_rows[p*MAX_PLY + nxt] = EMPTY_ENTRY;
                    else
                        for (int j = nxt; j < depth_reg && j < MAX_PLY; j++)
                            pv_rows[p*MAX_PLY + j] = pv_rows[nxt*MAX_PLY + j];
                end
            end
            CMD_CLEAR:
                wipe_stores();
            CMD_PV_READ:
            begin
                e = pv_get(p, r.column);
                o.rcode = e[31:0];
                o.rpiece = e[39:32];
            end
            default: ;
        endcase
        return o;
    endfunction

    // valid stays high after a transfer; the next call or the caller drops it
    task automatic send_move(move_req_t r, bit typed, order_res_t typed_res);
        order_res_t pred;
        pred = order_step(r);
        if (typed && pred != typed_res)
        begin
            $display("%0t predictor disagrees with typed row: exp %h got %h",
                     $time, typed_res, pred);
            errors++;
        end
        expected_q.push_back(pred);
        while (!idle_free && $urandom_range(99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, r.hpiece, r.hcode, r.mpiece, r.mcode,
                          r.column, r.ply, r.cmd};
        s_axis_tuser  <= r.leaf;
        s_axis_tlast  <= r.last;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain_and_config(logic [5:0] d);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        depth_reg = d;
    endtask

    // result side
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready <= !hold_off && (idle_free || $urandom_range(99) >= 33);
        end
    end

    initial
    begin
        order_res_t got;
        order_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[8:0], m_axis_tdata[40:9],
                       m_axis_tdata[48:41], m_axis_tlast};
                if (expected_q.size() == 0)
                begin
                    $display("%0t unexpected transfer: got %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.score != want.score || got.rcode != want.rcode ||
                        got.rpiece != want.rpiece || got.last != want.last)
                    begin
                        $display("%0t mismatch: exp score %0d code %h piece %h last %b",
                                 $time, want.score, want.rcode, want.rpiece, want.last);
                        $display("%0t           got score %0d code %h piece %h last %b",
                                 $time, got.score, got.rcode, got.rpiece, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic move_req_t rnd_req(logic [2:0] c);
        move_req_t r;
        r.cmd    = c;
        r.ply    = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(5));
        r.column = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
        r.mcode  = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(5));
        if ($urandom_range(9) == 0) r.mcode = '1;
        r.mpiece = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2));
        r.hcode  = ($urandom_range(1) == 0) ? r.mcode : $urandom;
        r.hpiece = ($urandom_range(1) == 0) ? r.mpiece : 8'($urandom);
        r.leaf   = 1'($urandom);
        r.last   = 1'($urandom);
        return r;
    endfunction

    initial
    begin
        dir_row_t   dir_rows[$];
        dir_row_t   dr;
        move_req_t  r;
        order_res_t none;
        logic [2:0] c;
        int         k;
        errors        = 0;
        idle_free     = 1'b0;
        hold_off      = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        depth_reg     = 6'd32;
        wipe_stores();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        none = '0;
        // after reset every pv entry reads as the empty marker
        dr.req = '{CMD_PV_READ, 5'd0, 5'd0, 32'h0, 8'h0, 32'h0, 8'h0, 1'b0, 1'b0};
        dr.has_res = 1; dr.res = '{9'd0, 32'hffff_ffff, 8'h00, 1'b0};
        dir_rows.push_back(dr);
        dr.req = '{CMD_PV_READ, 5'd31, 5'd31, '1, '1, '1, '1, 1'b1, 1'b1};
        dir_rows.push_back(dr);
        // empty move matches pv, both killers and the hash move
        dr.req = '{CMD_SCORE, 5'd31, 5'd0, '1, 8'h00, '1, 8'h00, 1'b0, 1'b1};
        dr.has_res = 1; dr.res = '{9'd349, 32'h0, 8'h0, 1'b1};
        dir_rows.push_back(dr);
        dr.req = '{CMD_SCORE, 5'd0, 5'd0, '1, 8'h01, '1, 8'h01, 1'b0, 1'b0};
        dr.has_res = 1; dr.res = '{9'd90, 32'h0, 8'h0, 1'b0};
        dir_rows.push_back(dr);
        dr.has_res = 0; dr.res = none;
        dr.req = '{CMD_KILLER, 5'd3, 5'd0, 32'h1234, 8'h5, '0, '0, 1'b0, 1'b0};
        dir_rows.push_back(dr);
        dr.req = '{CMD_KILLER, 5'd3, 5'd0, 32'h1234, 8'h5, '0, '0, 1'b0, 1'b0};
        dir_rows.push_back(dr);
        dr.req = '{CMD_KILLER, 5'd3, 5'd0, 32'h9, 8'h5, '0, '0, 1'b0, 1'b0};
        dir_rows.push_back(dr);
        dr.req = '{CMD_SCORE, 5'd3, 5'd0, 32'h1234, 8'h5, 32'h1234, 8'h5, 1'b0, 1'b1};
        dir_rows.push_back(dr);
        dr.req = '{CMD_SCORE, 5'd3, 5'd0, 32'h9, 8'h4, 32'h0, 8'h0, 1'b0, 1'b0};
        dir_rows.push_back(dr);
        dr.req = '{CMD_PV_UPDATE, 5'd31, 5'd0, 32'hab, 8'hff, '0, '0, 1'b0, 1'b0};
        dir_rows.push_back(dr);
        dr.req = '{CMD_PV_UPDATE, 5'd30, 5'd0, 32'hcd, 8'h1, '0, '0, 1'b0, 1'b0};
        dir_rows.push_back(dr);
        dr.req = '{CMD_PV_UPDATE, 5'd29, 5'd0, 32'hef, 8'h2, '0, '0, 1'b1, 1'b0};
        dir_rows.push_back(dr);
        dr.req = '{CMD_PV_UPDATE, 5'd28, 5'd0, 32'h77, 8'h3, '0, '0, 1'b0, 1'b0};
        dir_rows.push_back(dr);
        for (int j = 28; j < 32; j++)
        begin
            dr.req = '{CMD_PV_READ, 5'd28, 5'(j), '0, '0, '0, '0, 1'b0, 1'b0};
            dir_rows.push_back(dr);
        end
        dr.req = '{CMD_SCORE, 5'd31, 5'd0, 32'hab, 8'hff, '0, '0, 1'b0, 1'b1};
        dir_rows.push_back(dr);
        dr.req = '{3'd5, 5'd1, 5'd1, '1, '1, '1, '1, 1'b1, 1'b1};
        dr.has_res = 1; dr.res = none;
        dir_rows.push_back(dr);
        dr.req = '{3'd7, 5'd0, 5'd0, '0, '0, '0, '0, 1'b0, 1'b0};
        dir_rows.push_back(dr);
        dr.has_res = 0;
        dr.req = '{CMD_CLEAR, 5'd0, 5'd0, '0, '0, '0, '0, 1'b0, 1'b0};
        dir_rows.push_back(dr);
        dr.req = '{CMD_PV_READ, 5'd28, 5'd28, '0, '0, '0, '0, 1'b0, 1'b0};
        dr.has_res = 1; dr.res = '{9'd0, 32'hffff_ffff, 8'h00, 1'b0};
        dir_rows.push_back(dr);

        foreach (dir_rows[i])
            send_move(dir_rows[i].req, dir_rows[i].has_res, dir_rows[i].res);

        // random phases: each with its own depth, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: drain_and_config(6'd1);
                1: drain_and_config(6'd32);
                2: drain_and_config(6'd4);
                3: drain_and_config(6'($urandom_range(2, 31)));
                4: drain_and_config(6'd63);
                default: drain_and_config(6'd8);
            endcase
            idle_free = (ph == 1);
            if (ph == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            k = 0;
            while (k < N_RANDOM / 6)
            begin
                // mostly search-like sequences: record pv bottom-up, then killers, scores and pv reads
                if ($urandom_range(9) < 7)
                begin
                    for (int p = 7; p >= 0; p--)
                    begin
                        r = rnd_req(CMD_PV_UPDATE);
                        r.ply = 5'(p);
                        send_move(r, 0, none);
                        k++;
                    end
                    for (int n = 0; n < 6; n++)
                    begin
                        c = ($urandom_range(2) == 0) ? CMD_KILLER : CMD_SCORE;
                        if ($urandom_range(3) == 0) c = CMD_PV_READ;
                        send_move(rnd_req(c), 0, none);
                        k++;
                    end
                end
                else
                begin
                    c = 3'($urandom_range(7));
                    if (c == CMD_CLEAR && $urandom_range(3) != 0) c = CMD_SCORE;
                    send_move(rnd_req(c), 0, none);
                    k++;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("[move_ordering_killer_pv_table_core] OK");
        else
            $display("[move_ordering_killer_pv_table_core] ERROR");
        $finish;
    end

endmodule
